// ===== src/lcdc_pkg.sv =====
// ============================================================================
// lcdc_pkg
// Shared types and constants for the 4-bit character LCD write controller.
// ============================================================================
`default_nettype none

package lcdc_pkg;

   // Request modes
   localparam logic [2:0] MODE_TICK   = 3'd0;
   localparam logic [2:0] MODE_CMD    = 3'd1;
   localparam logic [2:0] MODE_DATA   = 3'd2;
   localparam logic [2:0] MODE_CURSOR = 3'd3;
   localparam logic [2:0] MODE_HEX    = 3'd4;

   // Configuration register indexes
   localparam logic [1:0] CSR_SETUP = 2'd0;
   localparam logic [1:0] CSR_ENABLE = 2'd1;
   localparam logic [1:0] CSR_SHORT = 2'd2;
   localparam logic [1:0] CSR_LONG = 2'd3;

   // Reset values of the timing registers
   localparam logic [7:0]  SETUP_RESET = 8'd2;
   localparam logic [7:0]  ENABLE_RESET = 8'd4;
   localparam logic [15:0] SHORT_RESET = 16'd200;
   localparam logic [23:0] LONG_RESET = 24'd20000;

   // Byte encoding constants
   localparam logic [7:0] CURSOR_BASE = 8'h80;
   localparam logic [7:0] HEX_ALPHA_OFS = 8'h37;
   localparam logic [7:0] HEX_DIGIT_OFS = 8'h30;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] value;
      logic [5:0] column;
      logic       row;
   } req_item_type;

   typedef struct packed {
      logic       reg_select;
      logic       enable_pin;
      logic [3:0] bus_nibble;
      logic       busy_res;
      logic       accepted;
      logic       rejected;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0]  setup_ticks;
      logic [7:0]  enable_ticks;
      logic [15:0] short_delay_ticks;
      logic [23:0] long_delay_ticks;
   } cfg_type;

   // Power-up nibbles: 3, 3, 3, 2
   function automatic logic [3:0] init_nibble(input logic [1:0] idx);
      logic [3:0] nib;
      case (idx)
         2'd3:    nib = 4'h2;
         default: nib = 4'h3;
      endcase
      return nib;
   endfunction

   // Power-up commands: function set, display on, entry mode, clear
   function automatic logic [7:0] init_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'h28;
         2'd1:    b = 8'h0C;
         2'd2:    b = 8'h06;
         default: b = 8'h01;
      endcase
      return b;
   endfunction

   // One nibble as an ASCII hex character
   function automatic logic [7:0] hex_char(input logic [3:0] h);
      logic [7:0] c;
      c = (h > 4'd9) ? ({4'b0, h} + HEX_ALPHA_OFS) : ({4'b0, h} + HEX_DIGIT_OFS);
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== src/lcdc_csr.sv =====
// ============================================================================
// lcdc_csr
// Timing configuration registers, written through the csr channel.
// ============================================================================
`default_nettype none

module lcdc_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [1:0]        wr_index,
   input  wire logic [23:0]       wr_data,
   output lcdc_pkg::cfg_type      cfg
);

   lcdc_pkg::cfg_type cfg_ff;
   lcdc_pkg::cfg_type cfg_in;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            lcdc_pkg::CSR_SETUP:  cfg_in.setup_ticks = wr_data[7:0];
            lcdc_pkg::CSR_ENABLE: cfg_in.enable_ticks = wr_data[7:0];
            lcdc_pkg::CSR_SHORT:  cfg_in.short_delay_ticks = wr_data[15:0];
            lcdc_pkg::CSR_LONG:   cfg_in.long_delay_ticks = wr_data;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setup_ticks <= lcdc_pkg::SETUP_RESET;
         cfg_ff.enable_ticks <= lcdc_pkg::ENABLE_RESET;
         cfg_ff.short_delay_ticks <= lcdc_pkg::SHORT_RESET;
         cfg_ff.long_delay_ticks <= lcdc_pkg::LONG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== src/lcdc_seq.sv =====
// ============================================================================
// lcdc_seq
// LCD sequencer: power-up sequence, byte/nibble timing and request handling.
// Each processed item advances the sequencer by one tick.
// ============================================================================
`default_nettype none

module lcdc_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step_en,
   input  lcdc_pkg::req_item_type    item,
   input  lcdc_pkg::cfg_type         cfg,
   output lcdc_pkg::rsp_item_type    result
);

   typedef enum logic [2:0] {
      PH_START,
      PH_IDLE,
      PH_SETUP,
      PH_ENABLE,
      PH_POST,
      PH_EXTRA
   } phase_type;

   typedef enum logic [1:0] {
      XW_NONE,
      XW_SHORT,
      XW_LONG
   } xw_type;

   typedef struct packed {
      phase_type   phase;
      logic [23:0] wait_cnt;
      logic [3:0]  init_step;
      logic [1:0]  pend_cnt;
      logic        low_next;
      logic [5:0]  pins;       // RS, E, D7..D4
      logic [8:0]  cur_unit;   // RS, byte
      logic        nib_only;
      xw_type      extra;
      logic        cursor_extra;
      logic [8:0]  pend0;
      logic [8:0]  pend1;
   } seq_state_type;

   localparam logic [3:0] INIT_DONE = 4'd8;
   localparam logic [3:0] INIT_BYTES = 4'd4;
   localparam int SETTLE_STEPS = 4;

   seq_state_type state_ff;
   seq_state_type state_in;
   logic          acc;
   logic          rej;

   // Drive RS and nibble with E low, then wait the setup time
   function automatic seq_state_type start_nibble(input seq_state_type s_i,
                                                  input logic [3:0] nib);
      seq_state_type s;
      s = s_i;
      s.pins = {s.cur_unit[8], 1'b0, nib};
      s.phase = PH_SETUP;
      s.wait_cnt = {16'b0, cfg.setup_ticks};
      return s;
   endfunction

   function automatic seq_state_type start_byte(input seq_state_type s_i,
                                                input logic [8:0] unit,
                                                input xw_type x);
      seq_state_type s;
      s = s_i;
      s.cur_unit = unit;
      s.nib_only = 1'b0;
      s.low_next = 1'b0;
      s.extra = x;
      s = start_nibble(s, unit[7:4]);
      return s;
   endfunction

   function automatic seq_state_type start_init_unit(input seq_state_type s_i);
      seq_state_type s;
      logic [3:0]    nib;
      s = s_i;
      if (s.init_step < INIT_BYTES) begin
         nib = lcdc_pkg::init_nibble(s.init_step[1:0]);
         s.cur_unit = {5'b0, nib};
         s.nib_only = 1'b1;
         s.low_next = 1'b0;
         s.extra = XW_NONE;
         s = start_nibble(s, nib);
      end else begin
         s = start_byte(s, {1'b0, lcdc_pkg::init_byte(s.init_step[1:0])},
                        (s.init_step[1:0] == 2'd3) ? XW_LONG : XW_SHORT);
      end
      return s;
   endfunction

   function automatic seq_state_type start_user(input seq_state_type s_i);
      seq_state_type s;
      xw_type        x;
      s = s_i;
      if (s.pend_cnt != 2'd0) begin
         x = s.cursor_extra ? XW_SHORT : XW_NONE;
         s.cursor_extra = 1'b0;
         s = start_byte(s, s.pend0, x);
      end else begin
         s.phase = PH_IDLE;
         s.wait_cnt = '0;
      end
      return s;
   endfunction

   function automatic seq_state_type unit_done(input seq_state_type s_i);
      seq_state_type s;
      s = s_i;
      if (s.init_step < INIT_DONE) begin
         s.init_step = s.init_step + 4'd1;
         if (s.init_step < INIT_DONE) begin
            s = start_init_unit(s);
         end else begin
            s = start_user(s);
         end
      end else begin
         if (s.pend_cnt != 2'd0) begin
            s.pend_cnt = s.pend_cnt - 2'd1;
            s.pend0 = s.pend1;
         end
         s = start_user(s);
      end
      return s;
   endfunction

   // End of the current timed phase
   function automatic seq_state_type finish_phase(input seq_state_type s_i);
      seq_state_type s;
      s = s_i;
      case (s.phase)
         PH_SETUP: begin
            s.pins[4] = 1'b1;
            s.phase = PH_ENABLE;
            s.wait_cnt = {16'b0, (cfg.enable_ticks == 8'd0) ? 8'd1 : cfg.enable_ticks};
         end
         PH_ENABLE: begin
            s.pins[4] = 1'b0;
            if (s.nib_only) begin
               s.phase = PH_EXTRA;
               s.wait_cnt = cfg.long_delay_ticks;
            end else if (!s.low_next) begin
               s.low_next = 1'b1;
               s = start_nibble(s, s.cur_unit[3:0]);
            end else begin
               s.low_next = 1'b0;
               s.phase = PH_POST;
               s.wait_cnt = {8'b0, cfg.short_delay_ticks};
            end
         end
         PH_POST: begin
            if (s.extra == XW_SHORT) begin
               s.extra = XW_NONE;
               s.phase = PH_EXTRA;
               s.wait_cnt = {8'b0, cfg.short_delay_ticks};
            end else if (s.extra == XW_LONG) begin
               s.extra = XW_NONE;
               s.phase = PH_EXTRA;
               s.wait_cnt = cfg.long_delay_ticks;
            end else begin
               s = unit_done(s);
            end
         end
         PH_EXTRA: s = unit_done(s);
         default:  s = s_i;
      endcase
      return s;
   endfunction

   // Skip zero-length phases; at most four back-to-back before E goes high
   function automatic seq_state_type settle(input seq_state_type s_i);
      seq_state_type s;
      s = s_i;
      for (int i = 0; i < SETTLE_STEPS; i++) begin
         if ((s.phase inside {PH_SETUP, PH_ENABLE, PH_POST, PH_EXTRA}) &&
             (s.wait_cnt == '0)) begin
            s = finish_phase(s);
         end
      end
      return s;
   endfunction

   // Next state for one item
   always_comb begin
      logic is_req;
      is_req = (item.mode inside {lcdc_pkg::MODE_CMD, lcdc_pkg::MODE_DATA,
                                  lcdc_pkg::MODE_CURSOR, lcdc_pkg::MODE_HEX});
      state_in = state_ff;
      acc = 1'b0;
      rej = 1'b0;
      case (state_ff.phase)
         PH_START: begin
            state_in.init_step = '0;
            state_in = start_init_unit(state_in);
            state_in = settle(state_in);
            rej = is_req;
         end
         PH_IDLE: begin
            if (is_req) begin
               acc = 1'b1;
               state_in.cursor_extra = 1'b0;
               case (item.mode)
                  lcdc_pkg::MODE_CMD: begin
                     state_in.pend0 = {1'b0, item.value};
                     state_in.pend_cnt = 2'd1;
                  end
                  lcdc_pkg::MODE_DATA: begin
                     state_in.pend0 = {1'b1, item.value};
                     state_in.pend_cnt = 2'd1;
                  end
                  lcdc_pkg::MODE_CURSOR: begin
                     state_in.pend0 = {1'b0, lcdc_pkg::CURSOR_BASE +
                                       {1'b0, item.row, 6'b0} + {2'b0, item.column}};
                     state_in.pend_cnt = 2'd1;
                     state_in.cursor_extra = 1'b1;
                  end
                  default: begin
                     state_in.pend0 = {1'b1, lcdc_pkg::hex_char(item.value[7:4])};
                     state_in.pend1 = {1'b1, lcdc_pkg::hex_char(item.value[3:0])};
                     state_in.pend_cnt = 2'd2;
                  end
               endcase
               state_in = start_user(state_in);
               state_in = settle(state_in);
            end
         end
         default: begin
            if (state_in.wait_cnt != '0) begin
               state_in.wait_cnt = state_in.wait_cnt - 24'd1;
            end
            state_in = settle(state_in);
            rej = is_req;
         end
      endcase
   end

   // Sequencer state; pending bytes hold no reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase <= PH_START;
         state_ff.wait_cnt <= '0;
         state_ff.init_step <= '0;
         state_ff.pend_cnt <= '0;
         state_ff.low_next <= 1'b0;
         state_ff.pins <= '0;
         state_ff.cur_unit <= '0;
         state_ff.nib_only <= 1'b0;
         state_ff.extra <= XW_NONE;
         state_ff.cursor_extra <= 1'b0;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

   // Pins as they stand after this item
   assign result.reg_select = state_in.pins[5];
   assign result.enable_pin = state_in.pins[4];
   assign result.bus_nibble = state_in.pins[3:0];
   assign result.busy_res = (state_in.phase != PH_IDLE);
   assign result.accepted = acc;
   assign result.rejected = rej;

endmodule

`default_nettype wire

// ===== src/char_lcd_nibble_write_controller_unit.sv =====
// ============================================================================
// char_lcd_nibble_write_controller_unit
// HD44780-style 4-bit LCD write controller: each request is one tick or a
// write request; one result per request gives the pin levels and status.
// ============================================================================
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall mode, value, column, row
//   rsp      out        rsp_valid/rsp_stall reg_select, enable_pin, bus_nibble,
//                                           busy_res, accepted, rejected
//   csr      in         csr_valid/csr_ready index (2b), wdata (24b)
//
// One request per cycle sustained while rsp is not stalled; a taken request
// is held in the input register, then its result in the result register.
// The sequencer state advances only when a request moves from the input
// register to the result register; the power-up sequence starts with the
// first request after reset. A stalled result holds the input register,
// which in turn stalls req. csr writes are always ready.
`default_nettype none

module char_lcd_nibble_write_controller_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_mode,
   input  wire logic [7:0]  req_value,
   input  wire logic [5:0]  req_column,
   input  wire logic        req_row,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_reg_select,
   output logic             rsp_enable_pin,
   output logic [3:0]       rsp_bus_nibble,
   output logic             rsp_busy_res,
   output logic             rsp_accepted,
   output logic             rsp_rejected,
   // configuration channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);

   logic                   in_valid_ff;
   logic                   in_valid_in;
   lcdc_pkg::req_item_type in_item_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   lcdc_pkg::rsp_item_type rsp_item_ff;
   lcdc_pkg::rsp_item_type seq_result;
   lcdc_pkg::cfg_type      cfg;
   logic                   advance;
   logic                   req_take;

   // Handshake control
   assign advance = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.mode <= req_mode;
         in_item_ff.value <= req_value;
         in_item_ff.column <= req_column;
         in_item_ff.row <= req_row;
      end
      if (advance) begin
         rsp_item_ff <= seq_result;
      end
   end

   lcdc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   lcdc_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (seq_result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_reg_select = rsp_item_ff.reg_select;
   assign rsp_enable_pin = rsp_item_ff.enable_pin;
   assign rsp_bus_nibble = rsp_item_ff.bus_nibble;
   assign rsp_busy_res = rsp_item_ff.busy_res;
   assign rsp_accepted = rsp_item_ff.accepted;
   assign rsp_rejected = rsp_item_ff.rejected;

endmodule

`default_nettype wire
